[sv/jset_pkg.sv]
// ============================================================================
// jset_pkg
// shared types, constants and codes for the julia set escape test
// ============================================================================
package jset_pkg;

    localparam int FRAC_BITS_DEF = 20;
    localparam int MAX_GRID_DEF  = 1024;

    localparam int COMP_W     = 32;
    localparam int PROD_W     = 64;
    localparam int COORD_W    = 10;
    localparam int GRID_W     = 11;
    localparam int SCALE_W    = 24;
    localparam int LIMIT_W    = 12;
    localparam int ESC_W      = 10;
    localparam int GLYPH_W    = 6;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;

    localparam logic [GRID_W-1:0]         GRID_SIZE_RST  = 11'd20;
    localparam logic [SCALE_W-1:0]        VIEW_SCALE_RST = 24'd1572864;
    localparam logic signed [COMP_W-1:0]  CONST_RE_RST   = -32'sd838861;
    localparam logic signed [COMP_W-1:0]  CONST_IM_RST   = 32'sd163578;
    localparam logic [LIMIT_W-1:0]        ITER_LIMIT_RST = 12'd200;
    localparam logic [ESC_W-1:0]          ESC_LIMIT_RST  = 10'd1000;

    localparam logic [GLYPH_W-1:0] GLYPH_OUT = 6'd32;
    localparam logic [GLYPH_W-1:0] GLYPH_IN  = 6'd42;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GRID_SIZE  = 3'd0,
        REG_VIEW_SCALE = 3'd1,
        REG_CONST_RE   = 3'd2,
        REG_CONST_IM   = 3'd3,
        REG_ITER_LIMIT = 3'd4,
        REG_ESC_LIMIT  = 3'd5
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD_X,
        ST_WAIT_X,
        ST_LOAD_Y,
        ST_WAIT_Y,
        ST_MUL,
        ST_UPD,
        ST_FINISH
    } jset_state_t;

    typedef struct packed {
        logic div_start;
        logic div_sel_y;
        logic load_re;
        logic load_im;
        logic mul_en;
        logic upd_en;
    } jset_ctl_t;

    typedef struct packed {
        logic div_done;
        logic escaped;
    } jset_sts_t;

endpackage

[sv/jset_div.sv]
// ============================================================================
// jset_div
// pixel to plane mapping: scale * (half - coord) / half, restoring divider
// one quotient bit per cycle, truncation toward zero, 32-bit saturation
// ============================================================================
module jset_div
#(
    parameter int MAX_GRID = jset_pkg::MAX_GRID_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [jset_pkg::SCALE_W-1:0]        view_scale,
    input  logic [$clog2(MAX_GRID)-1:0]         half,
    input  logic [jset_pkg::COORD_W-1:0]        coord,
    output logic signed [jset_pkg::COMP_W-1:0]  quot,
    output logic                                done
);
    import jset_pkg::*;

    localparam int HALF_W = $clog2(MAX_GRID);
    localparam int DIFF_W = ((HALF_W > COORD_W) ? HALF_W : COORD_W) + 1;
    localparam int MAGD_W = DIFF_W - 1;
    localparam int MAG_W  = SCALE_W + MAGD_W;
    localparam int CNT_W  = $clog2(MAG_W + 1);
    localparam logic [MAG_W-1:0] POS_LIM = MAG_W'(64'h7FFF_FFFF);
    localparam logic [MAG_W-1:0] NEG_LIM = MAG_W'(64'h8000_0000);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [HALF_W-1:0] rem_reg, rem_next;
    logic [MAG_W-1:0]  quo_reg, quo_next;
    logic              neg_reg, neg_next;

    logic [DIFF_W-1:0] diff;
    logic              diff_neg;
    logic [MAGD_W-1:0] diff_mag;
    logic [MAG_W-1:0]  num_mag;
    logic [HALF_W:0]   shifted;
    logic              ge;

    assign diff     = DIFF_W'(half) - DIFF_W'(coord);
    assign diff_neg = diff[DIFF_W-1];
    assign diff_mag = diff_neg ? MAGD_W'(-diff) : diff[MAGD_W-1:0];
    assign num_mag  = MAG_W'(view_scale) * MAG_W'(diff_mag);

    assign shifted  = {rem_reg, quo_reg[MAG_W-1]};
    assign ge       = (shifted >= {1'b0, half});

    always_comb
    begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        neg_next = neg_reg;
        if (start)
        begin
            rem_next = '0;
            quo_next = num_mag;
            neg_next = diff_neg;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? HALF_W'(shifted - {1'b0, half}) : shifted[HALF_W-1:0];
            quo_next = {quo_reg[MAG_W-2:0], ge};
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = busy_reg && (cnt_reg == CNT_W'(1));
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(MAG_W);
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        neg_reg <= neg_next;
    end

    always_comb
    begin
        if (!neg_reg)
        begin
            quot = (quo_reg > POS_LIM) ? 32'sh7FFF_FFFF : quo_reg[COMP_W-1:0];
        end
        else
        begin
            quot = (quo_reg > NEG_LIM) ? 32'sh8000_0000 : -quo_reg[COMP_W-1:0];
        end
    end

    assign done = done_reg;

endmodule

[sv/jset_cplx.sv]
// ============================================================================
// jset_cplx
// complex square-and-add unit: registered products, update and escape test
// ============================================================================
module jset_cplx
#(
    parameter int FRAC_BITS = jset_pkg::FRAC_BITS_DEF
)
(
    input  logic                                clk,
    input  jset_pkg::jset_ctl_t                 ctl,
    input  logic signed [jset_pkg::COMP_W-1:0]  div_q,
    input  logic signed [jset_pkg::COMP_W-1:0]  const_real,
    input  logic signed [jset_pkg::COMP_W-1:0]  const_imag,
    input  logic [jset_pkg::ESC_W-1:0]          escape_limit,
    output logic                                escaped
);
    import jset_pkg::*;

    logic signed [COMP_W-1:0] ar_reg, ar_next;
    logic signed [COMP_W-1:0] ai_reg, ai_next;
    logic signed [PROD_W-1:0] p_rr_reg, p_ii_reg, p_ri_reg;

    logic signed [PROD_W-1:0] ar_ext, ai_ext;
    logic signed [PROD_W-1:0] re_diff, re_shift, im_shift, re_sum, im_sum;
    logic signed [COMP_W-1:0] re_sat, im_sat;
    logic [PROD_W-1:0]        mag, bound;

    function automatic logic signed [COMP_W-1:0] sat_comp(input logic signed [PROD_W-1:0] v);
        logic signed [COMP_W-1:0] r;
        if (v > 64'sh0000_0000_7FFF_FFFF)
        begin
            r = 32'sh7FFF_FFFF;
        end
        else if (v < -64'sh0000_0000_8000_0000)
        begin
            r = 32'sh8000_0000;
        end
        else
        begin
            r = v[COMP_W-1:0];
        end
        return r;
    endfunction

    assign ar_ext   = {{(PROD_W-COMP_W){ar_reg[COMP_W-1]}}, ar_reg};
    assign ai_ext   = {{(PROD_W-COMP_W){ai_reg[COMP_W-1]}}, ai_reg};

    assign re_diff  = p_rr_reg - p_ii_reg;
    assign re_shift = re_diff >>> FRAC_BITS;
    assign im_shift = p_ri_reg >>> (FRAC_BITS - 1);
    assign re_sum   = re_shift + {{(PROD_W-COMP_W){const_real[COMP_W-1]}}, const_real};
    assign im_sum   = im_shift + {{(PROD_W-COMP_W){const_imag[COMP_W-1]}}, const_imag};
    assign re_sat   = sat_comp(re_sum);
    assign im_sat   = sat_comp(im_sum);

    assign mag      = PROD_W'(p_rr_reg) + PROD_W'(p_ii_reg);
    assign bound    = PROD_W'(escape_limit) << (2 * FRAC_BITS);
    assign escaped  = (mag > bound);

    always_comb
    begin
        ar_next = ar_reg;
        ai_next = ai_reg;
        if (ctl.load_re)
        begin
            ar_next = div_q;
        end
        else if (ctl.upd_en)
        begin
            ar_next = re_sat;
        end
        if (ctl.load_im)
        begin
            ai_next = div_q;
        end
        else if (ctl.upd_en)
        begin
            ai_next = im_sat;
        end
    end

    always_ff @(posedge clk)
    begin
        ar_reg <= ar_next;
        ai_reg <= ai_next;
        if (ctl.mul_en)
        begin
            p_rr_reg <= ar_ext * ar_ext;
            p_ii_reg <= ai_ext * ai_ext;
            p_ri_reg <= ar_ext * ai_ext;
        end
    end

endmodule

[sv/jset_ctrl.sv]
// ============================================================================
// jset_ctrl
// sequencer for mapping and iteration, iteration counter and result register
// ============================================================================
module jset_ctrl
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          inside_res,
    input  logic [jset_pkg::LIMIT_W-1:0]  iter_limit,
    input  jset_pkg::jset_sts_t           sts,
    output jset_pkg::jset_ctl_t           ctl
);
    import jset_pkg::*;

    jset_state_t        state_reg, state_next;
    logic [LIMIT_W-1:0] count_reg, count_next;
    logic               result_reg, result_next;
    logic               out_valid_reg, out_valid_next;
    logic               inside_reg, inside_next;
    logic               out_free;
    logic               stop_escape;
    logic               stop_limit;

    assign out_free    = !out_valid_reg || out_ready;
    assign stop_escape = (count_reg != '0) && sts.escaped;
    assign stop_limit  = (count_reg == iter_limit);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_LOAD_X;
                end
            end
            ST_LOAD_X: state_next = ST_WAIT_X;
            ST_WAIT_X:
            begin
                if (sts.div_done)
                begin
                    state_next = ST_LOAD_Y;
                end
            end
            ST_LOAD_Y: state_next = ST_WAIT_Y;
            ST_WAIT_Y:
            begin
                if (sts.div_done)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: state_next = ST_UPD;
            ST_UPD:
            begin
                if (stop_escape || stop_limit)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_MUL;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctl            = '0;
        in_ready       = 1'b0;
        count_next     = count_reg;
        result_next    = result_reg;
        out_valid_next = out_valid_reg && !out_ready;
        inside_next    = inside_reg;
        unique case (state_reg)
            ST_IDLE: in_ready = 1'b1;
            ST_LOAD_X:
            begin
                ctl.div_start = 1'b1;
                count_next    = '0;
            end
            ST_WAIT_X: ctl.load_re = sts.div_done;
            ST_LOAD_Y:
            begin
                ctl.div_start = 1'b1;
                ctl.div_sel_y = 1'b1;
            end
            ST_WAIT_Y:
            begin
                ctl.div_sel_y = 1'b1;
                ctl.load_im   = sts.div_done;
            end
            ST_MUL: ctl.mul_en = 1'b1;
            ST_UPD:
            begin
                if (stop_escape)
                begin
                    result_next = 1'b0;
                end
                else if (stop_limit)
                begin
                    result_next = 1'b1;
                end
                else
                begin
                    ctl.upd_en = 1'b1;
                    count_next = count_reg + LIMIT_W'(1);
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    inside_next    = result_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            result_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            result_reg    <= result_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        inside_reg <= inside_next;
    end

    assign out_valid  = out_valid_reg;
    assign inside_res = inside_reg;

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        sts.div_done |-> (state_reg == ST_WAIT_X || state_reg == ST_WAIT_Y))
        else $error("divider done outside a mapping wait");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPD) |-> (count_reg <= iter_limit))
        else $error("iteration count passed the limit");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_LOAD_X))
        else $error("accepted request did not start mapping");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_FINISH))
        else $error("result raised outside finish");

endmodule

[sv/julia_set_escape_test.sv]
// ============================================================================
// julia_set_escape_test
// julia set escape-time test for one pixel of a square grid
// ============================================================================
// channel   | signals                                   | handshake
// ----------+-------------------------------------------+----------------
// config    | cfg_we, cfg_index, cfg_data               | write on cfg_we
// pixel in  | in_valid, in_ready, pixel_x, pixel_y      | valid / ready
// result    | out_valid, out_ready, inside_res, glyph   | valid / ready
//
// a request maps x and y, then runs at most iteration_limit iterations;
// mapping x and y runs the restoring divider one quotient bit per cycle,
// and each iteration is a multiply state and an update state of the
// complex unit
// reset is asynchronous, active low, and loads the register defaults
// a new request is taken while an earlier result waits in the output register
// ============================================================================
module julia_set_escape_test
#(
    parameter int FRAC_BITS = jset_pkg::FRAC_BITS_DEF,
    parameter int MAX_GRID  = jset_pkg::MAX_GRID_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [jset_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [jset_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [jset_pkg::COORD_W-1:0]       pixel_x,
    input  logic [jset_pkg::COORD_W-1:0]       pixel_y,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               inside_res,
    output logic [jset_pkg::GLYPH_W-1:0]       glyph
);
    import jset_pkg::*;

    localparam int HALF_W = $clog2(MAX_GRID);
    localparam logic [HALF_W-1:0] HALF_MAX = HALF_W'(MAX_GRID / 2);

    logic [GRID_W-1:0]        grid_size_reg, grid_size_next;
    logic [SCALE_W-1:0]       view_scale_reg, view_scale_next;
    logic signed [COMP_W-1:0] const_re_reg, const_re_next;
    logic signed [COMP_W-1:0] const_im_reg, const_im_next;
    logic [LIMIT_W-1:0]       iter_limit_reg, iter_limit_next;
    logic [ESC_W-1:0]         esc_limit_reg, esc_limit_next;

    logic [COORD_W-1:0]       pixel_x_reg, pixel_y_reg;

    logic                     grid_big;
    logic [HALF_W-1:0]        half_raw, half;
    logic [COORD_W-1:0]       coord;
    logic signed [COMP_W-1:0] div_q;
    logic                     div_done;
    logic                     escaped;
    jset_ctl_t                ctl;
    jset_sts_t                sts;

    always_comb
    begin
        grid_size_next  = grid_size_reg;
        view_scale_next = view_scale_reg;
        const_re_next   = const_re_reg;
        const_im_next   = const_im_reg;
        iter_limit_next = iter_limit_reg;
        esc_limit_next  = esc_limit_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_GRID_SIZE:  grid_size_next  = cfg_data[GRID_W-1:0];
                REG_VIEW_SCALE: view_scale_next = cfg_data[SCALE_W-1:0];
                REG_CONST_RE:   const_re_next   = cfg_data[COMP_W-1:0];
                REG_CONST_IM:   const_im_next   = cfg_data[COMP_W-1:0];
                REG_ITER_LIMIT: iter_limit_next = cfg_data[LIMIT_W-1:0];
                REG_ESC_LIMIT:  esc_limit_next  = cfg_data[ESC_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_size_reg  <= GRID_SIZE_RST;
            view_scale_reg <= VIEW_SCALE_RST;
            const_re_reg   <= CONST_RE_RST;
            const_im_reg   <= CONST_IM_RST;
            iter_limit_reg <= ITER_LIMIT_RST;
            esc_limit_reg  <= ESC_LIMIT_RST;
        end
        else
        begin
            grid_size_reg  <= grid_size_next;
            view_scale_reg <= view_scale_next;
            const_re_reg   <= const_re_next;
            const_im_reg   <= const_im_next;
            iter_limit_reg <= iter_limit_next;
            esc_limit_reg  <= esc_limit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            pixel_x_reg <= pixel_x;
            pixel_y_reg <= pixel_y;
        end
    end

    // oversized grid clamps, half of zero counts as one
    assign grid_big = (32'(grid_size_reg) > MAX_GRID);
    assign half_raw = grid_big ? HALF_MAX : HALF_W'(grid_size_reg[GRID_W-1:1]);
    assign half     = (half_raw == '0) ? HALF_W'(1) : half_raw;
    assign coord    = ctl.div_sel_y ? pixel_y_reg : pixel_x_reg;

    assign sts.div_done = div_done;
    assign sts.escaped  = escaped;

    jset_div #(
        .MAX_GRID   (MAX_GRID)
    ) u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (ctl.div_start),
        .view_scale (view_scale_reg),
        .half       (half),
        .coord      (coord),
        .quot       (div_q),
        .done       (div_done)
    );

    jset_cplx #(
        .FRAC_BITS    (FRAC_BITS)
    ) u_cplx (
        .clk          (clk),
        .ctl          (ctl),
        .div_q        (div_q),
        .const_real   (const_re_reg),
        .const_imag   (const_im_reg),
        .escape_limit (esc_limit_reg),
        .escaped      (escaped)
    );

    jset_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .inside_res (inside_res),
        .iter_limit (iter_limit_reg),
        .sts        (sts),
        .ctl        (ctl)
    );

    assign glyph = inside_res ? GLYPH_IN : GLYPH_OUT;

endmodule
